// File: hdl/dpd_pkg.sv
// Shared constants, table text and stage type for the packet descrambler
package dpd_pkg;

    localparam int POS_W = 17;
    localparam int LEN_W = 16;

    localparam logic [31:0] KEY_MULT    = 32'h6765_7268;
    localparam logic [7:0]  TABLE_LIMIT = 8'd220;
    localparam logic [7:0]  MARKER_MIN  = 8'd10;
    localparam logic [7:0]  MARKER_XOR  = 8'hFF;

    // First 256 characters of the scramble text; index 0 sits in the top byte.
    localparam logic [8*256-1:0] TBL_TEXT = {
        "As part of this software beta version Mira", "bilis is ",
        "granting a limited access to the I", "CQ network, ",
        "servers, directories, listings, information and databases (\"",
        "I", "CQ Services and Information\"). The ",
        "I", "CQ Service and Information may databases (\"",
        "I", "CQ Services and In"
    };

    function automatic logic [7:0] tbl_byte(input logic [7:0] idx);
        return TBL_TEXT[{~idx, 3'b000} +: 8];
    endfunction

    // Byte held between the front (framing) stage and the back (decode) stage
    typedef struct packed {
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] len;
        logic             last;
    } t_stage;

endpackage

// File: hdl/dpd_if.sv
// Valid/ready stream interfaces for received and descrambled bytes
interface dpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       packet_start;

    modport source (output valid, output in_byte, output packet_start, input ready);
    modport sink   (input valid, input in_byte, input packet_start, output ready);
endinterface

interface dpd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       packet_end;
    logic       check_ok;

    modport source (output valid, output out_byte, output packet_end, output check_ok,
                    input ready);
    modport sink   (input valid, input out_byte, input packet_end, input check_ok,
                    output ready);
endinterface

// File: hdl/dpd_rom.sv
// Two-port synchronous ROM holding the scramble text table
module dpd_rom (
    input  logic       i_clk,
    input  logic       i_a_en,
    input  logic [7:0] i_a_addr,
    input  logic [7:0] i_b_addr,
    output logic [7:0] o_a_q,
    output logic [7:0] o_b_q
);

    logic [7:0] r_a_q;
    logic [7:0] r_b_q;

    // port A: pad lookup, advances with the stage register
    always_ff @(posedge i_clk) begin
        if (i_a_en) begin
            r_a_q <= dpd_pkg::tbl_byte(i_a_addr);
        end
    end

    // port B: free-running check lookup
    always_ff @(posedge i_clk) begin
        r_b_q <= dpd_pkg::tbl_byte(i_b_addr);
    end

    assign o_a_q = r_a_q;
    assign o_b_q = r_b_q;

endmodule

// File: hdl/dpd_front.sv
// Framing stage: byte position, length capture, end detect, table address
module dpd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dpd_in_if.sink          i_in,
    input  logic            i_adv,
    output logic            o_s1_valid,
    output dpd_pkg::t_stage o_s1,
    output logic            o_pad_en,
    output logic [7:0]      o_pad_addr
);

    logic [dpd_pkg::POS_W-1:0] r_pos;
    logic [dpd_pkg::POS_W-1:0] n_pos;
    logic [dpd_pkg::LEN_W-1:0] r_len;
    logic [dpd_pkg::LEN_W-1:0] cur_len;
    logic [dpd_pkg::POS_W-1:0] pos;
    logic [7:0]                d_lo;
    logic                      last;
    logic                      accept;
    logic                      r_s1_valid;
    dpd_pkg::t_stage           r_s1;

    assign i_in.ready = !r_s1_valid || i_adv;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        pos = i_in.packet_start ? '0 : r_pos;
        if (pos == dpd_pkg::POS_W'(0)) begin
            cur_len = {8'h00, i_in.in_byte};
        end else if (pos == dpd_pkg::POS_W'(1)) begin
            cur_len = {i_in.in_byte, r_len[7:0]};
        end else begin
            cur_len = r_len;
        end
        last  = (pos != '0) && (pos == ({1'b0, cur_len} + dpd_pkg::POS_W'(1)));
        n_pos = last ? '0 : pos + dpd_pkg::POS_W'(1);
        // block base of data offset (pos - 2), low byte only
        d_lo  = pos[7:0] - 8'd2;
    end

    assign o_pad_en   = accept;
    assign o_pad_addr = {d_lo[7:2], 2'b00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_len      <= '0;
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_pos      <= n_pos;
            r_len      <= cur_len;
            r_s1_valid <= 1'b1;
        end else if (i_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.data <= i_in.in_byte;
            r_s1.pos  <= pos;
            r_s1.len  <= cur_len;
            r_s1.last <= last;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

// File: hdl/dpd_back.sv
// Decode stage: key build, descramble XOR, marker verification, output register
module dpd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_s1_valid,
    input  dpd_pkg::t_stage i_s1,
    input  logic [7:0]      i_pad_q,
    input  logic [7:0]      i_chk_q,
    output logic [7:0]      o_chk_addr,
    output logic            o_adv,
    dpd_out_if.source       o_out
);

    logic [31:0] r_check;
    logic [31:0] n_check;
    logic [31:0] r_key;
    logic [31:0] n_key;
    logic [31:0] r_prod;
    logic [31:0] n_prod;
    logic [31:0] prod_lo;
    logic [7:0]  r_dbf;
    logic [7:0]  n_dbf;
    logic [7:0]  r_midx;
    logic [7:0]  n_midx;
    logic [7:0]  r_mexp;
    logic [7:0]  n_mexp;
    logic        r_verdict;
    logic        n_verdict;

    logic [dpd_pkg::POS_W-1:0] d;
    logic [dpd_pkg::POS_W-1:0] blk;
    logic [dpd_pkg::POS_W-1:0] lim;
    logic [31:0]               hex;
    logic [7:0]                key_byte;
    logic                      scr;
    logic [7:0]                ob;
    logic [31:0]               v;
    logic                      ok;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_end;
    logic       r_out_ok;

    assign o_adv      = i_s1_valid && (!r_out_valid || o_out.ready);
    assign o_chk_addr = r_dbf ^ r_check[15:8];
    // key product, low 32 bits only
    assign prod_lo    = dpd_pkg::KEY_MULT * 32'(i_s1.len);

    always_comb begin
        d        = i_s1.pos - dpd_pkg::POS_W'(2);
        blk      = {d[dpd_pkg::POS_W-1:2], 2'b00};
        lim      = (dpd_pkg::POS_W'(i_s1.len) + dpd_pkg::POS_W'(3)) >> 2;
        hex      = r_key + {24'h0, i_pad_q};
        key_byte = hex[{d[1:0], 3'b000} +: 8];
        scr      = i_en && (i_s1.pos >= dpd_pkg::POS_W'(6)) && (blk < lim);
        ob       = scr ? (i_s1.data ^ key_byte) : i_s1.data;
        v        = {r_dbf, ob, r_dbf, ob} ^ r_check;

        n_check   = r_check;
        n_key     = r_key;
        n_prod    = r_prod;
        n_dbf     = r_dbf;
        n_midx    = r_midx;
        n_mexp    = r_mexp;
        n_verdict = r_verdict;

        if (i_s1.pos == '0) begin
            n_check   = '0;
            n_key     = '0;
            n_dbf     = '0;
            n_midx    = '0;
            n_mexp    = '0;
            n_verdict = 1'b1;
        end else if (i_s1.pos == dpd_pkg::POS_W'(1)) begin
            // high length byte only, nothing to update here
            n_verdict = r_verdict;
        end else if (i_s1.pos <= dpd_pkg::POS_W'(5)) begin
            n_check[{d[1:0], 3'b000} +: 8] = i_s1.data;
            n_prod = prod_lo;
            if (i_s1.pos == dpd_pkg::POS_W'(5)) begin
                n_key = r_prod + {i_s1.data, r_check[23:0]};
            end
        end else begin
            if (d == dpd_pkg::POS_W'(4)) begin
                n_dbf = ob;
            end else if (d == dpd_pkg::POS_W'(6)) begin
                n_midx = v[31:24];
                n_mexp = v[23:16] ^ dpd_pkg::MARKER_XOR;
                if ((v[31:24] < dpd_pkg::MARKER_MIN) ||
                    (dpd_pkg::LEN_W'(v[31:24]) >= i_s1.len)) begin
                    n_verdict = 1'b0;
                end
                // check ROM was addressed with v[15:8] once byte four landed
                if ((v[15:8] < dpd_pkg::TABLE_LIMIT) &&
                    (v[7:0] != (i_chk_q ^ dpd_pkg::MARKER_XOR))) begin
                    n_verdict = 1'b0;
                end
            end else if ((d > dpd_pkg::POS_W'(6)) && (d == dpd_pkg::POS_W'(r_midx))) begin
                if (ob != r_mexp) begin
                    n_verdict = 1'b0;
                end
            end
        end

        ok = i_s1.last &&
             (!i_en || (n_verdict && (i_s1.len > dpd_pkg::LEN_W'(dpd_pkg::MARKER_MIN))));
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_check   <= n_check;
            r_key     <= n_key;
            r_prod    <= n_prod;
            r_dbf     <= n_dbf;
            r_midx    <= n_midx;
            r_mexp    <= n_mexp;
            r_verdict <= n_verdict;
            r_out_byte <= ob;
            r_out_end  <= i_s1.last;
            r_out_ok   <= ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_byte   = r_out_byte;
    assign o_out.packet_end = r_out_end;
    assign o_out.check_ok   = r_out_ok;

endmodule

// File: hdl/direct_packet_descrambler_unit.sv
// Direct-link packet descrambler top level
//
// Takes one received packet byte per transaction on i_in and returns one
// descrambled byte per transaction on o_out, in order. A packet is a 16-bit
// little-endian length L, a 32-bit check word, then data; the first six bytes
// pass through unchanged. The key is 0x67657268*L + check (mod 2^32); data
// blocks of four bytes from data offset 4 up to (L+3)/4 are XORed with the
// key plus a text-table byte. Decoded bytes 4 and 6 yield a marker index and
// expected marker value plus a table check; check_ok is reported on the final
// byte (packet_end), and is forced high when scrambling is disabled. A byte
// with packet_start high always opens a new packet; otherwise a new packet
// begins right after the last byte of the previous one.
// Throughput: one byte per clock, sustained, for as long as o_out is ready;
// a stalled o_out holds the framing stage and then the input. A taken byte
// goes through the framing register, then the result register. The text table
// is a two-port synchronous ROM: one port is addressed from the byte position
// as the byte is taken, the other from decoded byte four so the check entry
// is ready by data offset 6. The key product is formed while the check word
// arrives, so the key is ready at the first scrambled byte. The user must
// write the configuration bit through i_cfg_we / i_cfg_wdata (reset value 1)
// only while idle; the block does not enforce this.
module direct_packet_descrambler_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    dpd_in_if.sink    i_in,
    dpd_out_if.source o_out
);

    // scramble enable configuration register
    logic r_scramble_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scramble_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_scramble_en <= i_cfg_wdata;
        end
    end

    // framing stage -> decode stage
    logic            s1_valid;
    dpd_pkg::t_stage s1;
    logic            adv;

    // table ROM ports
    logic       pad_en;
    logic [7:0] pad_addr;
    logic [7:0] pad_q;
    logic [7:0] chk_addr;
    logic [7:0] chk_q;

    dpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_adv      (adv),
        .o_s1_valid (s1_valid),
        .o_s1       (s1),
        .o_pad_en   (pad_en),
        .o_pad_addr (pad_addr)
    );

    dpd_rom u_rom (
        .i_clk    (i_clk),
        .i_a_en   (pad_en),
        .i_a_addr (pad_addr),
        .i_b_addr (chk_addr),
        .o_a_q    (pad_q),
        .o_b_q    (chk_q)
    );

    dpd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (r_scramble_en),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .i_pad_q    (pad_q),
        .i_chk_q    (chk_q),
        .o_chk_addr (chk_addr),
        .o_adv      (adv),
        .o_out      (o_out)
    );

`ifndef SYNTH
    // the decode stage only advances a held byte
    a_adv_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |-> s1_valid)
        else $error("decode stage advanced with no byte held");

    // an empty framing stage always takes input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_valid |-> i_in.ready)
        else $error("input stalled while framing stage empty");

    // a pass verdict only ever comes with the packet's last byte
    a_ok_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.check_ok) |-> o_out.packet_end)
        else $error("check_ok raised off the final byte");

    // a packet end never falls on the first length byte
    a_end_not_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && s1.last) |-> (s1.pos != '0))
        else $error("packet end seen at position zero");
`endif

endmodule
